@@ design/tdbc_pkg.sv @@
// tdbc_pkg: types, codes and helpers shared by the fan timer display controller
// and its port checker. No dependencies.
`default_nettype none

package tdbc_pkg;

  // symbol codes on the display
  localparam logic [3:0] SYM_H     = 4'd10;
  localparam logic [3:0] SYM_I     = 4'd11;
  localparam logic [3:0] SYM_BLANK = 4'd12;
  localparam logic [3:0] SYM_ZERO  = 4'd0;

  // fan mode codes
  localparam logic [1:0] FAN_RUN = 2'd1;
  localparam logic [1:0] FAN_SET = 2'd2;

  // register indexes (byte address = 4 * index)
  localparam logic REG_TICKS_PER_UPDATE  = 1'b0;
  localparam logic REG_UPDATES_PER_BLINK = 1'b1;

  localparam logic [7:0] TICKS_PER_UPDATE_RST  = 8'd10;
  localparam logic [7:0] UPDATES_PER_BLINK_RST = 8'd10;

  localparam logic [6:0] HOURS_MAX = 7'd99;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_TIMING  = 2'd1,
    MODE_SETTING = 2'd2
  } disp_mode_t;

  typedef struct packed {
    logic [1:0] fan_mode;
    logic [6:0] wanted_hours;
    logic [5:0] wanted_minutes;
    logic [6:0] current_hours;
    logic [5:0] current_minutes;
  } in_word_t;

  typedef struct packed {
    logic [3:0] digit_left;
    logic [3:0] digit_mid_left;
    logic [3:0] digit_mid_right;
    logic [3:0] digit_right;
    logic       dot_on;
  } out_word_t;

  // tens and ones of a value up to 127 (exact by reciprocal 103/1024 below 179)
  function automatic logic [7:0] split_dec(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    prod = {7'd0, v} * 14'd103;
    tens = prod[13:10];
    ones = v - ({3'd0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

@@ design/timer_display_blink_controller.sv @@
// timer_display_blink_controller: fan timer display, four symbols and a colon dot.
// Uses tdbc_pkg for payload types, symbol codes and the decimal split.
//
//   port group   dir   handshake          payload
//   in_*         in    in_valid/in_stall  in_word  (fan mode, wanted and current time)
//   out_*        out   out_valid/out_stall out_word (four symbols, dot)
//   apb          in    psel/penable/pready paddr, pwdata, prdata (two 8-bit registers)
//
// one word in per cycle while in_stall is low, its result in the output register on the next cycle
// the state update and decimal split feed the state registers, which are also the
// output registers; the input takes a word whenever the output is empty or drained
// in_stall rises only while a result sits unread under out_stall
// synchronous reset: start mode, counters zero, symbols blank, dot off,
// registers back to 10
`default_nettype none

module timer_display_blink_controller (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire tdbc_pkg::in_word_t  in_word,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      tdbc_pkg::out_word_t out_word,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready
);

  tdbc_pkg::disp_mode_t mode_r, mode_nxt;
  logic [7:0] tpu_r;
  logic [7:0] upb_r;
  logic [7:0] tick_r, tick_nxt;
  logic [7:0] blink_r, blink_nxt;
  logic [3:0] sym_r   [4];
  logic [3:0] sym_nxt [4];
  logic       dot_r, dot_nxt;
  logic       out_valid_r;

  logic       in_acc;
  logic       upd;
  logic [7:0] tick_inc;
  logic [7:0] blink_base;
  logic [7:0] blink_inc;
  logic       blink_due;
  logic       all_blank;
  logic       none_blank;
  logic       show;
  logic [6:0] cur_h_sat;
  logic [6:0] want_h_sat;
  logic [7:0] cur_h_dec, cur_m_dec, want_h_dec, want_m_dec;

  assign pready   = 1'b1;
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r <= tdbc_pkg::TICKS_PER_UPDATE_RST;
      upb_r <= tdbc_pkg::UPDATES_PER_BLINK_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == tdbc_pkg::REG_UPDATES_PER_BLINK) begin
        upb_r <= pwdata[7:0];
      end else begin
        tpu_r <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == tdbc_pkg::REG_TICKS_PER_UPDATE) begin
      prdata = {24'd0, tpu_r};
    end else begin
      prdata = {24'd0, upb_r};
    end
  end

  // prescaler and decimal split
  assign tick_inc = tick_r + 8'd1;
  assign upd      = (tick_inc == tpu_r);

  assign cur_h_sat  = (in_word.current_hours > tdbc_pkg::HOURS_MAX) ?
                      tdbc_pkg::HOURS_MAX : in_word.current_hours;
  assign want_h_sat = (in_word.wanted_hours > tdbc_pkg::HOURS_MAX) ?
                      tdbc_pkg::HOURS_MAX : in_word.wanted_hours;
  assign cur_h_dec  = tdbc_pkg::split_dec(cur_h_sat);
  assign cur_m_dec  = tdbc_pkg::split_dec({1'b0, in_word.current_minutes});
  assign want_h_dec = tdbc_pkg::split_dec(want_h_sat);
  assign want_m_dec = tdbc_pkg::split_dec({1'b0, in_word.wanted_minutes});

  // leaving timing for setting restarts the blink phase before this update's count
  assign blink_base = (mode_r == tdbc_pkg::MODE_TIMING &&
                       in_word.fan_mode == tdbc_pkg::FAN_SET) ? 8'd0 : blink_r;
  assign blink_inc  = blink_base + 8'd1;
  assign blink_due  = (blink_inc == upb_r);

  always_comb begin
    all_blank  = 1'b1;
    none_blank = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (sym_r[i] == tdbc_pkg::SYM_BLANK) begin
        none_blank = 1'b0;
      end else begin
        all_blank = 1'b0;
      end
    end
  end

  assign show = blink_due ? all_blank : none_blank;

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    if (upd) begin
      case (mode_r)
        tdbc_pkg::MODE_START: begin
          if (in_word.fan_mode == tdbc_pkg::FAN_RUN) mode_nxt = tdbc_pkg::MODE_TIMING;
        end
        tdbc_pkg::MODE_TIMING: begin
          if (in_word.fan_mode == tdbc_pkg::FAN_SET) mode_nxt = tdbc_pkg::MODE_SETTING;
        end
        tdbc_pkg::MODE_SETTING: begin
          if (in_word.fan_mode == tdbc_pkg::FAN_RUN) mode_nxt = tdbc_pkg::MODE_TIMING;
        end
        default: mode_nxt = mode_r;
      endcase
    end
  end

  // display, dot and counters
  always_comb begin
    sym_nxt   = sym_r;
    dot_nxt   = dot_r;
    blink_nxt = blink_r;
    tick_nxt  = upd ? 8'd0 : tick_inc;
    if (upd) begin
      case (mode_r)
        tdbc_pkg::MODE_START: begin
          if (in_word.fan_mode == tdbc_pkg::FAN_RUN) begin
            sym_nxt[1] = tdbc_pkg::SYM_BLANK;
            sym_nxt[2] = tdbc_pkg::SYM_BLANK;
          end else begin
            sym_nxt[1] = tdbc_pkg::SYM_H;
            sym_nxt[2] = tdbc_pkg::SYM_I;
          end
        end
        tdbc_pkg::MODE_TIMING: begin
          if (in_word.wanted_hours == 7'd0) begin
            for (int i = 0; i < 4; i++) sym_nxt[i] = tdbc_pkg::SYM_ZERO;
            dot_nxt   = 1'b1;
            blink_nxt = blink_base;
          end else begin
            sym_nxt[0] = cur_h_dec[7:4];
            sym_nxt[1] = cur_h_dec[3:0];
            sym_nxt[2] = cur_m_dec[7:4];
            sym_nxt[3] = cur_m_dec[3:0];
            blink_nxt  = blink_due ? 8'd0 : blink_inc;
            if (blink_due) dot_nxt = ~dot_r;
          end
        end
        tdbc_pkg::MODE_SETTING: begin
          blink_nxt = blink_due ? 8'd0 : blink_inc;
          if (show) begin
            sym_nxt[0] = want_h_dec[7:4];
            sym_nxt[1] = want_h_dec[3:0];
            sym_nxt[2] = want_m_dec[7:4];
            sym_nxt[3] = want_m_dec[3:0];
            dot_nxt    = 1'b1;
          end else begin
            for (int i = 0; i < 4; i++) sym_nxt[i] = tdbc_pkg::SYM_BLANK;
            dot_nxt = 1'b0;
          end
        end
        default: begin
          sym_nxt = sym_r;
        end
      endcase
    end
  end

  // state registers double as the result register: they change only on accept,
  // and accept happens only when the previous result has been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= tdbc_pkg::MODE_START;
      tick_r      <= 8'd0;
      blink_r     <= 8'd0;
      dot_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) sym_r[i] <= tdbc_pkg::SYM_BLANK;
    end else begin
      if (in_acc) begin
        mode_r  <= mode_nxt;
        tick_r  <= tick_nxt;
        blink_r <= blink_nxt;
        dot_r   <= dot_nxt;
        sym_r   <= sym_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid                = out_valid_r;
  assign out_word.digit_left      = sym_r[0];
  assign out_word.digit_mid_left  = sym_r[1];
  assign out_word.digit_mid_right = sym_r[2];
  assign out_word.digit_right     = sym_r[3];
  assign out_word.dot_on          = dot_r;

endmodule

`default_nettype wire

@@ design/tdbc_checker.sv @@
// tdbc_checker: port-level checks on the fan timer display controller,
// bound to timer_display_blink_controller. Uses tdbc_pkg for the word types.
`default_nettype none

module tdbc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire tdbc_pkg::out_word_t out_word
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // an empty output never blocks the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // every accepted word yields a result next cycle
  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted word gave no result");

  // the dot is only lit with the left and right symbols shown
  a_dot_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.dot_on |->
      out_word.digit_left != tdbc_pkg::SYM_BLANK &&
      out_word.digit_right != tdbc_pkg::SYM_BLANK)
    else $error("dot lit over blank symbols");

endmodule

bind timer_display_blink_controller tdbc_checker u_tdbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
